/* hw/rtl/lcd4_pkg.sv */
// Shared types, constants and helper functions for the character LCD 4-bit interface.
`timescale 1ns / 1ps

package lcd4_pkg;

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_INSTR  = 2'd1,
    CMD_DATA   = 2'd2,
    CMD_NUMBER = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_DONE
  } fe_state_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ENABLE_HALF = 2'd0;
  localparam logic [1:0] REG_RESET_WAIT  = 2'd1;
  localparam logic [1:0] REG_INSTR_WAIT  = 2'd2;
  localparam logic [1:0] REG_CHAR_WAIT   = 2'd3;

  localparam logic [15:0] ENABLE_HALF_RST = 16'd50;
  localparam logic [15:0] RESET_WAIT_RST  = 16'd20000;
  localparam logic [15:0] INSTR_WAIT_RST  = 16'd5000;
  localparam logic [15:0] CHAR_WAIT_RST   = 16'd5000;

  localparam logic [3:0] SOFT_RESET_NIBBLE = 4'h3;
  localparam logic [3:0] MODE4_NIBBLE      = 4'h2;
  localparam logic [3:0] ASCII_DIGIT_HIGH  = 4'h3;
  localparam logic [3:0] INIT_LAST_STEP    = 4'd11;
  localparam logic [3:0] INIT_MODE_STEP    = 4'd3;
  localparam int         NUM_DIGITS        = 5;
  localparam int         CONV_CYCLES       = 8;

  typedef struct packed {
    logic [15:0] enable_half_us;
    logic [15:0] reset_wait_us;
    logic [15:0] instr_wait_us;
    logic [15:0] char_wait_us;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  data_byte;
    logic [19:0] bcd;
    logic [2:0]  ndig;
  } q_entry_t;

  // Front-to-queue transaction
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } push_t;

  // One double-dabble step: correct each digit, then shift in one bit
  function automatic logic [19:0] dabble_bit(input logic [19:0] bcd, input logic b);
    logic [19:0] adj;
    adj = bcd;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (adj[d*4 +: 4] >= 4'd5) adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
    end
    return {adj[18:0], b};
  endfunction

  function automatic logic [19:0] dabble_two(input logic [19:0] bcd, input logic [1:0] bits);
    return dabble_bit(dabble_bit(bcd, bits[1]), bits[0]);
  endfunction

  // Nibble sequence of the power-on init command
  function automatic logic [3:0] init_nibble(input logic [3:0] step);
    logic [3:0] n;
    unique case (step)
      4'd0, 4'd1, 4'd2: n = SOFT_RESET_NIBBLE;
      4'd3:             n = MODE4_NIBBLE;
      4'd5:             n = 4'hF;
      4'd7:             n = 4'h6;
      4'd9:             n = 4'h1;
      4'd11:            n = 4'h2;
      default:          n = 4'h0;
    endcase
    return n;
  endfunction

endpackage

/* hw/rtl/char_lcd_4bit_interface.sv */
// Top level: APB register file, command front end, queue and nibble sequencer.
// A byte or init command is written to the queue when accepted; its first transfer is then
//   registered in the output stage. A number is converted to BCD in the front end, then pushed.
// Throughput: one transfer per cycle from the sequencer while out_ready does not stall it;
//   init 12, byte 2, number 2..10 transfers. The front end takes no new command during a number.
// Reset: synchronous active-low rst_n empties the queue and output stage, loads register defaults.
`timescale 1ns / 1ps

module char_lcd_4bit_interface (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reg_select,
  output logic [3:0]  out_nibble,
  output logic [15:0] out_pulse_us,
  output logic [15:0] out_wait_after_us,
  output logic        out_last
);
  import lcd4_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;
  push_t      push;
  logic       q_full, head_valid, pop;
  q_entry_t   head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ENABLE_HALF: cfg_nxt.enable_half_us = pwdata[15:0];
        REG_RESET_WAIT:  cfg_nxt.reset_wait_us  = pwdata[15:0];
        REG_INSTR_WAIT:  cfg_nxt.instr_wait_us  = pwdata[15:0];
        REG_CHAR_WAIT:   cfg_nxt.char_wait_us   = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLE_HALF: prdata = {16'd0, cfg_r.enable_half_us};
      REG_RESET_WAIT:  prdata = {16'd0, cfg_r.reset_wait_us};
      REG_INSTR_WAIT:  prdata = {16'd0, cfg_r.instr_wait_us};
      REG_CHAR_WAIT:   prdata = {16'd0, cfg_r.char_wait_us};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_half_us <= ENABLE_HALF_RST;
      cfg_r.reset_wait_us  <= RESET_WAIT_RST;
      cfg_r.instr_wait_us  <= INSTR_WAIT_RST;
      cfg_r.char_wait_us   <= CHAR_WAIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcd4_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (cmd_t'(in_cmd)),
    .in_value (in_value),
    .q_full   (q_full),
    .push     (push)
  );

  lcd4_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  lcd4_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reg_select    (out_reg_select),
    .out_nibble        (out_nibble),
    .out_pulse_us      (out_pulse_us),
    .out_wait_after_us (out_wait_after_us),
    .out_last          (out_last)
  );

endmodule

/* hw/rtl/lcd4_front.sv */
// Front end: accepts host commands, converts numbers to BCD, pushes queue entries.
`timescale 1ns / 1ps

module lcd4_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcd4_pkg::cmd_t    in_cmd,
  input  logic [15:0]       in_value,
  input  logic              q_full,
  output lcd4_pkg::push_t   push
);
  import lcd4_pkg::*;

  fe_state_t   state_r, state_nxt;
  logic [15:0] bin_r, bin_nxt;
  logic [19:0] bcd_r, bcd_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  ndig;
  logic        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  // Count significant digits; zero still shows one digit
  always_comb begin
    if (bcd_r[19:16] != 4'd0)      ndig = 3'd5;
    else if (bcd_r[15:12] != 4'd0) ndig = 3'd4;
    else if (bcd_r[11:8] != 4'd0)  ndig = 3'd3;
    else if (bcd_r[7:4] != 4'd0)   ndig = 3'd2;
    else                           ndig = 3'd1;
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    accept    = 1'b0;
    push      = '0;
    unique case (state_r)
      FE_IDLE: begin
        in_ready = !q_full;
        accept   = in_valid && !q_full;
        if (accept) begin
          if (in_cmd == CMD_NUMBER) begin
            bin_nxt   = in_value;
            bcd_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = FE_CONV;
          end else begin
            push.push            = 1'b1;
            push.entry.cmd       = in_cmd;
            push.entry.data_byte = in_value[7:0];
            push.entry.ndig      = 3'd1;
          end
        end
      end
      FE_CONV: begin
        bcd_nxt = dabble_two(bcd_r, bin_r[15:14]);
        bin_nxt = {bin_r[13:0], 2'b00};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(CONV_CYCLES - 1)) state_nxt = FE_DONE;
      end
      FE_DONE: begin
        // hold until the queue has room
        if (!q_full) begin
          push.push       = 1'b1;
          push.entry.cmd  = CMD_NUMBER;
          push.entry.bcd  = bcd_r;
          push.entry.ndig = ndig;
          state_nxt       = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

endmodule

/* hw/rtl/lcd4_queue.sv */
// Two-entry queue between the command front end and the bus sequencer.
`timescale 1ns / 1ps

module lcd4_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  lcd4_pkg::push_t    push,
  output logic               full,
  output logic               head_valid,
  output lcd4_pkg::q_entry_t head,
  input  logic               pop
);
  import lcd4_pkg::*;

  q_entry_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push.push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, push.push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) mem_r[wr_ptr_r] <= push.entry;
  end

endmodule

/* hw/rtl/lcd4_back.sv */
// Back end: walks a queued command; one nibble transfer per unstalled cycle.
`timescale 1ns / 1ps

module lcd4_back (
  input  logic               clk,
  input  logic               rst_n,
  input  lcd4_pkg::cfg_t     cfg,
  input  logic               head_valid,
  input  lcd4_pkg::q_entry_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_reg_select,
  output logic [3:0]         out_nibble,
  output logic [15:0]        out_pulse_us,
  output logic [15:0]        out_wait_after_us,
  output logic               out_last
);
  import lcd4_pkg::*;

  logic [3:0]  step_r, step_nxt;
  logic        valid_r, valid_nxt;
  logic        rs_r, last_r;
  logic [3:0]  nib_r;
  logic [15:0] pulse_r, wait_r;

  logic        advance, is_last, rs;
  logic [3:0]  nib, digit;
  logic [2:0]  pos;
  logic [15:0] wait_us, pulse;

  assign advance = head_valid && (!valid_r || out_ready);
  assign pos     = (3'(NUM_DIGITS) - head.ndig) + step_r[3:1];
  assign pulse   = (cfg.enable_half_us == 16'd0) ? 16'd1 : cfg.enable_half_us;

  // most significant digit sits at position zero
  always_comb begin
    case (pos)
      3'd0:    digit = head.bcd[19:16];
      3'd1:    digit = head.bcd[15:12];
      3'd2:    digit = head.bcd[11:8];
      3'd3:    digit = head.bcd[7:4];
      default: digit = head.bcd[3:0];
    endcase
  end

  always_comb begin
    rs      = 1'b0;
    nib     = 4'h0;
    wait_us = 16'd0;
    is_last = 1'b0;
    unique case (head.cmd)
      CMD_INIT: begin
        nib     = init_nibble(step_r);
        is_last = (step_r == INIT_LAST_STEP);
        if (step_r < INIT_MODE_STEP)                         wait_us = cfg.reset_wait_us;
        else if (step_r == INIT_MODE_STEP || step_r[0])      wait_us = cfg.instr_wait_us;
      end
      CMD_INSTR, CMD_DATA: begin
        rs      = (head.cmd == CMD_DATA);
        nib     = step_r[0] ? head.data_byte[3:0] : head.data_byte[7:4];
        is_last = step_r[0];
        if (step_r[0]) wait_us = rs ? cfg.char_wait_us : cfg.instr_wait_us;
      end
      CMD_NUMBER: begin
        rs      = 1'b1;
        nib     = step_r[0] ? digit : ASCII_DIGIT_HIGH;
        is_last = step_r[0] && (step_r[3:1] == head.ndig - 3'd1);
        if (step_r[0]) wait_us = cfg.char_wait_us;
      end
      default: ;
    endcase
  end

  always_comb begin
    pop       = advance && is_last;
    step_nxt  = step_r;
    if (advance) step_nxt = is_last ? 4'd0 : step_r + 4'd1;
    valid_nxt = advance || (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rs_r    <= rs;
      nib_r   <= nib;
      pulse_r <= pulse;
      wait_r  <= wait_us;
      last_r  <= is_last;
    end
  end

  assign out_valid         = valid_r;
  assign out_reg_select    = rs_r;
  assign out_nibble        = nib_r;
  assign out_pulse_us      = pulse_r;
  assign out_wait_after_us = wait_r;
  assign out_last          = last_r;

endmodule

/* dv/tb_char_lcd_4bit_interface.sv */
// Testbench for the character LCD 4-bit interface: command stimulus and a nibble predictor.
`timescale 1ns / 1ps

module tb_char_lcd_4bit_interface;
  import lcd4_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 140;
  localparam int PHASE_ITEMS   = 20;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] pulse_us;
    logic [15:0] wait_after_us;
    logic        last;
  } lcd_xfer_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [15:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic        out_reg_select;
  logic [3:0]  out_nibble;
  logic [15:0] out_pulse_us;
  logic [15:0] out_wait_after_us;
  logic        out_last;

  char_lcd_4bit_interface u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reg_select    (out_reg_select),
    .out_nibble        (out_nibble),
    .out_pulse_us      (out_pulse_us),
    .out_wait_after_us (out_wait_after_us),
    .out_last          (out_last)
  );

  cfg_t      timing_shadow;
  lcd_xfer_t pending_xfers[$];
  int        cycle_count;
  int        mismatch_count;
  int        cmds_sent;
  int        xfers_checked;
  int        reg_writes;
  int        cmd_kind_count[4];
  bit        send_idle_on;
  bit        recv_idle_on;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transfers still pending", cycle_count,
               pending_xfers.size());
      $display("char_lcd_4bit_interface regression: fail");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH %0d: %s", mismatch_count, msg);
  endtask

  // ---------------- predictor ----------------

  // Expand one command into its enable-pulse transfers and queue them
  task automatic predict_transfers(input cmd_t cmd, input logic [15:0] value);
    logic        rs_list[12];
    logic [3:0]  nib_list[12];
    logic [15:0] wait_list[12];
    logic [7:0]  bytes[5];
    logic [15:0] pulse;
    int          n;
    int          nbytes;
    int          rest;
    int          div;
    int          d;
    bit          started;
    logic        rs;
    logic [15:0] byte_wait;
    lcd_xfer_t   x;
    n = 0;
    nbytes = 0;
    rs = 1'b0;
    byte_wait = timing_shadow.instr_wait_us;
    pulse = (timing_shadow.enable_half_us == 16'd0) ? 16'd1 : timing_shadow.enable_half_us;
    case (cmd)
      CMD_INIT: begin
        for (int i = 0; i < 3; i++) begin
          rs_list[n] = 1'b0; nib_list[n] = SOFT_RESET_NIBBLE;
          wait_list[n] = timing_shadow.reset_wait_us; n++;
        end
        rs_list[n] = 1'b0; nib_list[n] = MODE4_NIBBLE;
        wait_list[n] = timing_shadow.instr_wait_us; n++;
        bytes[0] = 8'h0F; bytes[1] = 8'h06; bytes[2] = 8'h01; bytes[3] = 8'h02;
        nbytes = 4;
      end
      CMD_INSTR: begin
        bytes[0] = value[7:0];
        nbytes = 1;
      end
      CMD_DATA: begin
        rs = 1'b1;
        byte_wait = timing_shadow.char_wait_us;
        bytes[0] = value[7:0];
        nbytes = 1;
      end
      default: begin
        rs = 1'b1;
        byte_wait = timing_shadow.char_wait_us;
        rest = value;
        div = 10000;
        started = 1'b0;
        while (div > 0) begin
          d = rest / div;
          if (d > 0 || started) begin
            started = 1'b1;
            bytes[nbytes] = 8'h30 + d[7:0];
            nbytes++;
          end
          rest = rest - d * div;
          div = div / 10;
        end
        if (!started) begin
          bytes[0] = 8'h30;
          nbytes = 1;
        end
      end
    endcase
    for (int b = 0; b < nbytes; b++) begin
      rs_list[n] = rs; nib_list[n] = bytes[b][7:4]; wait_list[n] = 16'd0; n++;
      rs_list[n] = rs; nib_list[n] = bytes[b][3:0]; wait_list[n] = byte_wait; n++;
    end
    for (int i = 0; i < n; i++) begin
      x.reg_select    = rs_list[i];
      x.nibble        = nib_list[i];
      x.pulse_us      = pulse;
      x.wait_after_us = wait_list[i];
      x.last          = (i == n - 1);
      pending_xfers.push_back(x);
    end
  endtask

  // ---------------- result side ----------------

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int stall;
      stall = recv_idle_on ? $urandom_range(0, 14) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    lcd_xfer_t got;
    lcd_xfer_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_reg_select, out_nibble, out_pulse_us, out_wait_after_us, out_last};
      if (pending_xfers.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer rs=%0b nib=%h pulse=%0d wait=%0d last=%0b",
                                got.reg_select, got.nibble, got.pulse_us, got.wait_after_us,
                                got.last));
      end else begin
        want = pending_xfers.pop_front();
        xfers_checked++;
        if (got !== want)
          note_mismatch($sformatf({"transfer %0d: exp rs=%0b nib=%h pulse=%0d wait=%0d last=%0b",
                                   " got rs=%0b nib=%h pulse=%0d wait=%0d last=%0b"},
                                  xfers_checked, want.reg_select, want.nibble, want.pulse_us,
                                  want.wait_after_us, want.last, got.reg_select, got.nibble,
                                  got.pulse_us, got.wait_after_us, got.last));
      end
    end
  end

  // ---------------- drivers ----------------

  task automatic send_command(input cmd_t cmd, input logic [15:0] value);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    predict_transfers(cmd, value);
    cmds_sent++;
    cmd_kind_count[cmd]++;
  endtask

  // Hold the sender until every queued transfer has come out, then let the pipe settle
  task automatic wait_drained;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_xfers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom_range(0, 65535)), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ENABLE_HALF: timing_shadow.enable_half_us = value;
      REG_RESET_WAIT:  timing_shadow.reset_wait_us  = value;
      REG_INSTR_WAIT:  timing_shadow.instr_wait_us  = value;
      default:         timing_shadow.char_wait_us   = value;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_readback(input logic [1:0] idx);
    logic [15:0] want;
    case (idx)
      REG_ENABLE_HALF: want = timing_shadow.enable_half_us;
      REG_RESET_WAIT:  want = timing_shadow.reset_wait_us;
      REG_INSTR_WAIT:  want = timing_shadow.instr_wait_us;
      default:         want = timing_shadow.char_wait_us;
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== want)
      note_mismatch($sformatf("register %0d readback: exp %0d got %0d", idx, want,
                              prdata[15:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [15:0] pick_timing(input logic [15:0] low);
    case ($urandom_range(0, 3))
      0:       return low;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 9));
      1:       return 16'($urandom_range(0, 255));
      2:       return 16'($urandom_range(0, 999));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---------------- tests ----------------

  // Reset timing, every command, byte and number extremes
  task automatic test_directed_commands;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    for (int i = 0; i < 4; i++) cfg_readback(i[1:0]);
    send_command(CMD_INIT, 16'h0000);
    send_command(CMD_INSTR, 16'h0000);
    send_command(CMD_INSTR, 16'h00FF);
    send_command(CMD_INSTR, 16'hFFA5);   // upper byte ignored
    send_command(CMD_DATA, 16'h0000);
    send_command(CMD_DATA, 16'h00FF);
    send_command(CMD_DATA, 16'hAB5A);
    send_command(CMD_NUMBER, 16'd0);     // single '0'
    send_command(CMD_NUMBER, 16'd7);
    send_command(CMD_NUMBER, 16'd10);
    send_command(CMD_NUMBER, 16'd100);
    send_command(CMD_NUMBER, 16'd9999);
    send_command(CMD_NUMBER, 16'd10000);
    send_command(CMD_NUMBER, 16'd32768);
    send_command(CMD_NUMBER, 16'd65535);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    send_command(CMD_INIT, 16'hFFFF);
    send_command(CMD_NUMBER, 16'd1005);
    send_command(CMD_DATA, 16'h0041);
    wait_drained();
  endtask

  // Zero, one and full-scale timing values and their complements, with readback
  task automatic test_register_extremes;
    logic [15:0] setting;
    for (int s = 0; s < 3; s++) begin
      setting = (s == 0) ? 16'h0000 : (s == 1) ? 16'h0001 : 16'hFFFF;
      cfg_write(REG_ENABLE_HALF, setting);
      cfg_write(REG_RESET_WAIT, ~setting);
      cfg_write(REG_INSTR_WAIT, setting);
      cfg_write(REG_CHAR_WAIT, ~setting);
      for (int i = 0; i < 4; i++) cfg_readback(i[1:0]);
      send_command(CMD_INIT, 16'h0000);
      send_command(CMD_INSTR, 16'($urandom_range(0, 65535)));
      send_command(CMD_NUMBER, 16'($urandom_range(0, 65535)));
      wait_drained();
    end
  endtask

  // Random commands in phases, each with its own timing and idle pattern
  task automatic test_random_traffic;
    int sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      cfg_write(REG_ENABLE_HALF, pick_timing(16'h0001));
      cfg_write(REG_RESET_WAIT, pick_timing(16'h0000));
      cfg_write(REG_INSTR_WAIT, pick_timing(16'h0000));
      cfg_write(REG_CHAR_WAIT, pick_timing(16'h0000));
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_command(cmd_t'($urandom_range(0, 3)), pick_value());
        sent++;
      end
      wait_drained();
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    in_cmd   = CMD_INIT;
    in_value = '0;
    cycle_count    = 0;
    mismatch_count = 0;
    cmds_sent      = 0;
    xfers_checked  = 0;
    reg_writes     = 0;
    for (int i = 0; i < 4; i++) cmd_kind_count[i] = 0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    timing_shadow = '{ENABLE_HALF_RST, RESET_WAIT_RST, INSTR_WAIT_RST, CHAR_WAIT_RST};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_commands();
    test_register_extremes();
    test_random_traffic();
    wait_drained();

    $display("covered %0d commands (init %0d, instr %0d, data %0d, number %0d)", cmds_sent,
             cmd_kind_count[0], cmd_kind_count[1], cmd_kind_count[2], cmd_kind_count[3]);
    $display("checked %0d transfers over %0d register writes, %0d mismatches", xfers_checked,
             reg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("char_lcd_4bit_interface regression: pass");
    end else begin
      $display("char_lcd_4bit_interface regression: fail");
    end
    $finish;
  end

endmodule
